// ===== hdl/wdo_pkg.sv =====
package wdo_pkg;

  localparam int ACC_W      = 32;
  localparam int SAMPLE_W   = 16;
  localparam int TIDX_W     = 10;
  localparam int LOOP_W     = 11;
  localparam int FRAC_W     = 5;
  localparam int DIV_CNT_W  = 5;
  localparam int CFG_IDX_W  = 2;

  localparam logic [FRAC_W-1:0] MAX_FRAC = FRAC_W'(21);

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_LOAD  = 2'd1,
    OP_STEP  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RATE  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_RANGE = 2'd3
  } stat_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOOP_START = 2'd0,
    CFG_LOOP_END   = 2'd1,
    CFG_PHASE_RATE = 2'd2,
    CFG_FRAC_BITS  = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_FOLD,
    ST_ADD,
    ST_WRAP,
    ST_LOOK,
    ST_READ,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic chk;
    logic div_step;
    logic fold;
    logic add;
    logic wrap;
    logic look;
    logic rd_take;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic rate_high;
    logic loop_empty;
    logic need_fold;
    logic div_last;
    logic idx_oob;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== hdl/wdo_ram.sv =====
module wdo_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/wdo_ctrl.sv =====
module wdo_ctrl
  import wdo_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  dp_sts_t     sts,
  output dp_cmd_t     cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (op == OP_STEP) ? ST_CHECK : ST_DONE;
        end
      end
      ST_CHECK: begin
        if (sts.rate_high || sts.loop_empty) begin
          state_next = ST_DONE;
        end else if (sts.need_fold) begin
          state_next = ST_DIV;
        end else begin
          state_next = ST_ADD;
        end
      end
      ST_DIV: begin
        if (sts.div_last) begin
          state_next = ST_FOLD;
        end
      end
      ST_FOLD: state_next = ST_ADD;
      ST_ADD:  state_next = ST_WRAP;
      ST_WRAP: state_next = ST_LOOK;
      ST_LOOK: state_next = sts.idx_oob ? ST_DONE : ST_READ;
      ST_READ: state_next = ST_DONE;
      ST_DONE: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_CHECK: cmd.chk      = 1'b1;
      ST_DIV:   cmd.div_step = 1'b1;
      ST_FOLD:  cmd.fold     = 1'b1;
      ST_ADD:   cmd.add      = 1'b1;
      ST_WRAP:  cmd.wrap     = 1'b1;
      ST_LOOK:  cmd.look     = 1'b1;
      ST_READ:  cmd.rd_take  = 1'b1;
      ST_DONE:  cmd.out_load = sts.out_free;
      default:  cmd          = '0;
    endcase
  end

endmodule

// ===== hdl/wdo_datapath.sv =====
module wdo_datapath
  import wdo_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  dp_cmd_t                     cmd,
  output dp_sts_t                     sts,
  input  logic                        cfg_valid,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [31:0]                 cfg_data,
  input  logic [1:0]                  op,
  input  logic [TIDX_W-1:0]           table_index,
  input  logic signed [SAMPLE_W-1:0]  table_sample,
  input  logic [ACC_W-1:0]            phase_value,
  input  logic                        block_start,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [SAMPLE_W-1:0]  sample,
  output logic [ACC_W-1:0]            phase_out,
  output logic [1:0]                  status
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic [ACC_W-1:0] DEPTH_W = ACC_W'(TABLE_DEPTH);

  logic [LOOP_W-1:0]    loop_start;
  logic [LOOP_W-1:0]    loop_end;
  logic [ACC_W-1:0]     phase_rate;
  logic [FRAC_W-1:0]    fraction_bits;
  logic [FRAC_W-1:0]    bits;
  logic [ACC_W-1:0]     offset;
  logic [ACC_W-1:0]     limit;
  logic [ACC_W-1:0]     span;
  logic [ACC_W-1:0]     acc;
  logic [ACC_W-1:0]     num;
  logic [ACC_W-1:0]     rem;
  logic [ACC_W:0]       rem_sh;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 bstart;
  logic [SAMPLE_W-1:0]  res_sample;
  logic [1:0]           res_status;
  logic [ACC_W-1:0]     idx;
  logic [ACC_W-1:0]     tidx_ext;
  logic                 ram_we;
  logic [SAMPLE_W-1:0]  ram_rdata;

  assign bits     = (fraction_bits > MAX_FRAC) ? MAX_FRAC : fraction_bits;
  assign idx      = acc >> bits;
  assign tidx_ext = ACC_W'(table_index);
  assign rem_sh   = {rem, num[ACC_W-1]};
  assign ram_we   = cmd.capture && (op == OP_WRITE) && (tidx_ext < DEPTH_W);

  assign sts.rate_high  = phase_rate > (limit >> 1);
  assign sts.loop_empty = loop_end <= loop_start;
  assign sts.need_fold  = bstart && (acc >= limit);
  assign sts.div_last   = &cnt;
  assign sts.idx_oob    = idx >= DEPTH_W;
  assign sts.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      loop_start    <= '0;
      loop_end      <= LOOP_W'(1024);
      phase_rate    <= '0;
      fraction_bits <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_LOOP_START: loop_start    <= cfg_data[LOOP_W-1:0];
        CFG_LOOP_END:   loop_end      <= cfg_data[LOOP_W-1:0];
        CFG_PHASE_RATE: phase_rate    <= cfg_data;
        CFG_FRAC_BITS:  fraction_bits <= cfg_data[FRAC_W-1:0];
        default:        phase_rate    <= phase_rate;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    offset <= ACC_W'(loop_start) << bits;
    limit  <= ACC_W'(loop_end) << bits;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (cmd.capture && (op == OP_LOAD)) begin
      acc <= phase_value;
    end else if (cmd.fold) begin
      acc <= offset + rem;
    end else if (cmd.add) begin
      acc <= acc + phase_rate;
    end else if (cmd.wrap && (acc >= limit)) begin
      acc <= acc - span;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      bstart     <= block_start;
      res_sample <= '0;
      res_status <= STAT_OK;
    end
    if (cmd.chk) begin
      span <= limit - offset;
      num  <= acc - offset;
      rem  <= '0;
      cnt  <= '0;
      if (sts.rate_high) begin
        res_status <= STAT_RATE;
      end else if (sts.loop_empty) begin
        res_status <= STAT_EMPTY;
      end
    end
    if (cmd.div_step) begin
      if (rem_sh >= {1'b0, span}) begin
        rem <= ACC_W'(rem_sh - {1'b0, span});
      end else begin
        rem <= rem_sh[ACC_W-1:0];
      end
      num <= num << 1;
      cnt <= cnt + 1'b1;
    end
    if (cmd.look && sts.idx_oob) begin
      res_status <= STAT_RANGE;
    end
    if (cmd.rd_take) begin
      res_sample <= ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      sample    <= res_sample;
      status    <= res_status;
      phase_out <= acc;
    end
  end

  wdo_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tidx_ext[AW-1:0]),
    .wdata (table_sample),
    .re    (cmd.look),
    .raddr (idx[AW-1:0]),
    .rdata (ram_rdata)
  );

endmodule

// ===== hdl/wavetable_dds_oscillator_core.sv =====
// Steps from accept to result: write, load and unused items go straight to the
// result; a step item runs the check and ends there on a rate or loop error, else
// runs the block-start fold if needed (a one-bit-per-cycle remainder unit and a
// fold step), the add, the wrap and the table lookup, and reads the table if in range.
// A new item waits until the last result is loaded; a held result stalls the next item.
// Reset clears the config, accumulator, output valid and control, but not the table.
module wavetable_dds_oscillator_core
  import wdo_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [31:0]                 cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  op,
  input  logic [TIDX_W-1:0]           table_index,
  input  logic signed [SAMPLE_W-1:0]  table_sample,
  input  logic [ACC_W-1:0]            phase_value,
  input  logic                        block_start,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [SAMPLE_W-1:0]  sample,
  output logic [ACC_W-1:0]            phase_out,
  output logic [1:0]                  status
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  wdo_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .op       (op),
    .sts      (sts),
    .cmd      (cmd)
  );

  wdo_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .op           (op),
    .table_index  (table_index),
    .table_sample (table_sample),
    .phase_value  (phase_value),
    .block_start  (block_start),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sample       (sample),
    .phase_out    (phase_out),
    .status       (status)
  );

endmodule
